[rtl/afq_pkg.sv]
// Package for the affine float quantizer: register addresses, output modes, limits.
// No dependencies.
`default_nettype none
package afq_pkg;
  localparam int unsigned AddrWidth = 4;
  localparam logic [AddrWidth-1:0] AddrScale = 4'h0;
  localparam logic [AddrWidth-1:0] AddrZero  = 4'h4;
  localparam logic [AddrWidth-1:0] AddrType  = 4'h8;
  localparam logic [31:0] ScaleReset = 32'h3F80_0000;

  typedef enum logic {
    OUT_U8  = 1'b0,
    OUT_S16 = 1'b1
  } out_type_t;

  localparam logic signed [15:0] U8Max  = 16'sd255;
  localparam logic signed [15:0] U8Min  = 16'sd0;
  localparam logic signed [15:0] S16Max = 16'sd32767;
  localparam logic signed [15:0] S16Min = -16'sd32767;
endpackage
`default_nettype wire

[rtl/affine_float_quantizer.sv]
// Top level of the affine float quantizer: float multiply, round, offset, saturate.
// Depends on afq_pkg.
//
// Usage:
//  - Input channel: value_bits with in_valid/in_ready, one fp32 element per item.
//  - Output channel: quantized with out_valid/out_ready, one result per item.
//  - APB port sets scale_inverse (0x0), zero_point (0x4), out_type (0x8).
//    Write configuration only while no item is in flight.
// Pipeline: input register -> 24x24 significand multiply -> product register ->
//   align/round/offset/saturate -> output register; one item per cycle sustained
//   while out_ready is high.
// Each stage advances when the next stage is empty or being drained, so a stall
//   on out_ready backs up stage by stage; in_ready drops only when all are full.
// Reset (rst, synchronous) empties the pipeline and loads scale 1.0,
//   zero point 0 and unsigned 8-bit mode.
// NaN products give the low end of the range; infinities and huge values
//   saturate. Exponent alignment is a single barrel shift of the product.
`default_nettype none
module affine_float_quantizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] value_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] quantized,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [afq_pkg::AddrWidth-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [31:0] scale_inverse;
  logic [7:0]  zero_point;
  afq_pkg::out_type_t out_type;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_inverse <= afq_pkg::ScaleReset;
      zero_point    <= 8'd0;
      out_type      <= afq_pkg::OUT_U8;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        afq_pkg::AddrScale: scale_inverse <= pwdata;
        afq_pkg::AddrZero:  zero_point    <= pwdata[7:0];
        afq_pkg::AddrType:  out_type      <= afq_pkg::out_type_t'(pwdata[0]);
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr)
      afq_pkg::AddrScale: prdata = scale_inverse;
      afq_pkg::AddrZero:  prdata = {24'd0, zero_point};
      afq_pkg::AddrType:  prdata = {31'd0, out_type};
      default:            prdata = 32'd0;
    endcase
  end

  // Stage valids and advance enables.
  logic v1, v2, v3;
  logic adv1, adv2, adv3;
  assign adv3 = !v3 || out_ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_ready = adv1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // Stage 1: input register.
  logic [31:0] x1;
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) x1 <= value_bits;
  end

  // Stage 1 decode and multiply.
  logic        xs, ks;
  logic [7:0]  xe, ke;
  logic [22:0] xf, kf;
  logic        x_nan, k_nan, x_inf, k_inf, x_zero, k_zero;
  logic [23:0] xm, km;
  logic [9:0]  xeu, keu;
  always_comb begin
    xs = x1[31]; xe = x1[30:23]; xf = x1[22:0];
    ks = scale_inverse[31]; ke = scale_inverse[30:23]; kf = scale_inverse[22:0];
    x_nan  = (xe == 8'hFF) && (xf != 23'd0);
    k_nan  = (ke == 8'hFF) && (kf != 23'd0);
    x_inf  = (xe == 8'hFF) && (xf == 23'd0);
    k_inf  = (ke == 8'hFF) && (kf == 23'd0);
    x_zero = (xe == 8'd0) && (xf == 23'd0);
    k_zero = (ke == 8'd0) && (kf == 23'd0);
    xm  = {(xe != 8'd0), xf};
    km  = {(ke != 8'd0), kf};
    xeu = (xe == 8'd0) ? 10'd1 : {2'd0, xe};
    keu = (ke == 8'd0) ? 10'd1 : {2'd0, ke};
  end

  // Product register.
  logic [47:0] pm2;
  logic [9:0]  pe2;
  logic        ps2, pnan2, pinf2;
  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      pm2   <= xm * km;
      pe2   <= xeu + keu;
      ps2   <= xs ^ ks;
      pnan2 <= x_nan || k_nan || (x_inf && k_zero) || (k_inf && x_zero);
      pinf2 <= (x_inf || k_inf) && !x_nan && !k_nan;
    end
  end

  // Stage 2: value = pm2 * 2^(pe2 - 300). Integer part = pm2 >> (300 - pe2).
  // Keep one extra bit for the half. Magnitudes >= 2^33 saturate.
  logic [9:0]  sh;
  logic        big;
  logic [33:0] ih;       // integer part with half bit appended
  logic [33:0] mag;      // rounded magnitude
  logic signed [35:0] sv;
  logic signed [15:0] res;
  always_comb begin
    // pe2 ranges 2..510 (2..508 for finite inputs). Value >= 2^33 if msb position 47 + pe2 - 300 >= 33.
    big = pinf2 || ((pm2 != 48'd0) && (pe2 >= 10'd286));
    sh  = 10'd299 - pe2; // shift keeping one fraction bit
    if (big) begin
      ih = '1;
    end else if (pe2 > 10'd299) begin
      ih = 34'(pm2 << (pe2 - 10'd299));
    end else if (sh > 10'd47) begin
      ih = 34'd0;
    end else begin
      ih = 34'(pm2 >> sh[5:0]);
    end
    mag = big ? 34'h3_FFFF_FFFF : ({1'b0, ih[33:1]} + {33'd0, ih[0]});
    sv  = ps2 ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    sv  = sv + $signed({28'd0, zero_point});
    if (out_type == afq_pkg::OUT_U8) begin
      if (pnan2) res = afq_pkg::U8Min;
      else if (sv > 36'sd255) res = afq_pkg::U8Max;
      else if (sv < 36'sd0) res = afq_pkg::U8Min;
      else res = 16'(sv);
    end else begin
      if (pnan2) res = afq_pkg::S16Min;
      else if (sv > 36'sd32767) res = afq_pkg::S16Max;
      else if (sv < -36'sd32767) res = afq_pkg::S16Min;
      else res = 16'(sv);
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) quantized <= res;
  end
endmodule
`default_nettype wire

[rtl/afq_checker.sv]
// Port-level checks for the affine float quantizer, bound to the top level.
// Depends on afq_pkg.
`default_nettype none
module afq_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic signed [15:0] quantized,
  input wire logic pready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quantized))
    else $error("result changed while stalled");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quantized >= afq_pkg::S16Min)
    else $error("result below range");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule
bind affine_float_quantizer afq_checker u_afq_checker (.*);
`default_nettype wire
